// ===== design/disco_payload_parser_defines.svh =====
// Assertion macros for the discovery payload parser.
// Included by the top level; depends on nothing else.
`ifndef DISCO_PAYLOAD_PARSER_DEFINES_SVH
`define DISCO_PAYLOAD_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DPP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DPP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dpp_pkg.sv =====
// Shared types, constants and helpers for the discovery payload parser.
// No dependencies.
package dpp_pkg;

   localparam int TXID_BYTES_DEF    = 12;
   localparam int MAX_ENDPOINTS_DEF = 16;
   localparam int MAX_PAYLOAD_DEF   = 2048;

   localparam int EP_BYTES   = 18;
   localparam int KEY_BYTES  = 32;
   localparam int ADDR_BYTES = 16;

   localparam int CNT_W      = 12;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int TDATA_W    = 48;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef enum logic [2:0] {
      ROLE_TYPE     = 3'd0,
      ROLE_VERSION  = 3'd1,
      ROLE_TXID     = 3'd2,
      ROLE_KEY      = 3'd3,
      ROLE_PADDING  = 3'd4,
      ROLE_EP_ADDR  = 3'd5,
      ROLE_EP_PORT  = 3'd6,
      ROLE_IGNORED  = 3'd7
   } role_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_INVALID     = 2'd1,
      STAT_UNSUPPORTED = 2'd2,
      STAT_TOO_LONG    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_PING  = 2'd0,
      KIND_PONG  = 2'd1,
      KIND_CALL  = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PING_CODE = 2'd0,
      CSR_PONG_CODE = 2'd1,
      CSR_CALL_CODE = 2'd2
   } csr_index_type;

   typedef enum logic {
      REC_BYTE    = 1'b0,
      REC_SUMMARY = 1'b1
   } rec_kind_type;

   typedef struct packed {
      rec_kind_type   kind;
      logic [7:0]     byte_value;
      role_type       byte_role;
      logic [4:0]     field_offset;
      logic [3:0]     endpoint_slot;
      logic [7:0]     message_type;
      status_type     status;
      logic           key_present;
      logic [11:0]    padding_len;
      logic [4:0]     endpoint_count;
   } rec_type;

   // queue write request: one byte record, or a byte record plus summary
   typedef struct packed {
      logic push;
      logic pair;
   } push_type;

   // earlier matches win when codes are equal
   function automatic kind_type kind_of(input logic [7:0] t, input logic [7:0] ping,
                                        input logic [7:0] pong, input logic [7:0] call);
      kind_type k;
      if (t == ping)      k = KIND_PING;
      else if (t == pong) k = KIND_PONG;
      else if (t == call) k = KIND_CALL;
      else                k = KIND_OTHER;
      return k;
   endfunction

endpackage

// ===== design/dpp_parser.sv =====
// Input stage, per-message state and byte/summary classification.
// Depends on dpp_pkg.
module dpp_parser #(
   parameter int TXID_BYTES    = dpp_pkg::TXID_BYTES_DEF,
   parameter int MAX_ENDPOINTS = dpp_pkg::MAX_ENDPOINTS_DEF,
   parameter int MAX_PAYLOAD   = dpp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dpp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [7:0]                        in_byte,
   input  logic                              in_last,
   input  logic                              q_room,
   output dpp_pkg::push_type                 q_push,
   output dpp_pkg::rec_type                  rec_byte,
   output dpp_pkg::rec_type                  rec_sum
);
   import dpp_pkg::*;

   localparam logic [CNT_W-1:0] MAX_L      = CNT_W'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] TXID_L     = CNT_W'(TXID_BYTES);
   localparam logic [CNT_W-1:0] KEY_END_L  = CNT_W'(TXID_BYTES + KEY_BYTES);
   localparam logic [CNT_W-1:0] PONG_ADDR_L = CNT_W'(TXID_BYTES + ADDR_BYTES);
   localparam logic [CNT_W-1:0] PONG_END_L = CNT_W'(TXID_BYTES + ADDR_BYTES + 2);
   localparam logic [CNT_W-1:0] KEY_L      = CNT_W'(KEY_BYTES);
   localparam logic [4:0]       MAX_EP_L   = 5'(MAX_ENDPOINTS);
   localparam logic [4:0]       EP_LAST_L  = 5'(EP_BYTES - 1);
   localparam logic [4:0]       ADDR_L     = 5'(ADDR_BYTES);

   // configuration
   logic [7:0] ping_code_ff, pong_code_ff, call_code_ff;

   // input stage
   logic       stg_valid_ff, stg_valid_in;
   logic [7:0] stg_byte_ff;
   logic       stg_last_ff;
   logic       consume;

   // message state
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]       type_seen_ff, type_seen_in;
   logic [7:0]       version_seen_ff, version_seen_in;
   logic             key_nonzero_ff, key_nonzero_in;
   logic [4:0]       group_phase_ff, group_phase_in;
   logic [4:0]       group_count_ff, group_count_in;
   // body length mod 18 and whole groups, independent of the type decode
   logic [4:0]       rest_phase_ff, rest_phase_in;
   logic [4:0]       rest_groups_ff, rest_groups_in;

   logic [CNT_W-1:0] pos, r, r_key, r_port;
   logic [CNT_W-1:0] len, rest, after, after_key;
   kind_type         kind_now, kind_sum;
   role_type         role;
   logic [4:0]       off;
   logic [3:0]       slot;
   status_type       status;
   logic             has_key;
   logic [11:0]      pad;
   logic [4:0]       ep_cnt;

   assign consume      = stg_valid_ff && q_room;
   assign in_ready     = !stg_valid_ff || consume;
   assign stg_valid_in = in_valid ? 1'b1 : (stg_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         ping_code_ff <= 8'd1;
         pong_code_ff <= 8'd2;
         call_code_ff <= 8'd3;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PING_CODE: ping_code_ff <= csr_wdata;
            CSR_PONG_CODE: pong_code_ff <= csr_wdata;
            CSR_CALL_CODE: call_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (in_ready) begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stg_byte_ff <= in_byte;
         stg_last_ff <= in_last;
      end
   end

   // per-byte classification
   always_comb begin
      pos             = byte_count_ff;
      r               = pos - CNT_W'(2);
      r_key           = r - TXID_L;
      r_port          = r - PONG_ADDR_L;
      kind_now        = kind_of(type_seen_ff, ping_code_ff, pong_code_ff, call_code_ff);
      role            = ROLE_IGNORED;
      off             = 5'd0;
      slot            = 4'd0;
      type_seen_in    = type_seen_ff;
      version_seen_in = version_seen_ff;
      key_nonzero_in  = key_nonzero_ff;
      group_phase_in  = group_phase_ff;
      group_count_in  = group_count_ff;
      rest_phase_in   = rest_phase_ff;
      rest_groups_in  = rest_groups_ff;

      if (pos >= MAX_L) begin
         role = ROLE_IGNORED;
      end else if (pos == CNT_W'(0)) begin
         role         = ROLE_TYPE;
         type_seen_in = stg_byte_ff;
      end else if (pos == CNT_W'(1)) begin
         role            = ROLE_VERSION;
         version_seen_in = stg_byte_ff;
      end else begin
         if (rest_phase_ff == EP_LAST_L) begin
            rest_phase_in = 5'd0;
            if (rest_groups_ff < MAX_EP_L) rest_groups_in = rest_groups_ff + 5'd1;
         end else begin
            rest_phase_in = rest_phase_ff + 5'd1;
         end

         case (kind_now)
            KIND_PING: begin
               if (r < TXID_L) begin
                  role = ROLE_TXID;
                  off  = r[4:0];
               end else if (r < KEY_END_L) begin
                  role = ROLE_KEY;
                  off  = r_key[4:0];
                  if (stg_byte_ff != 8'd0) key_nonzero_in = 1'b1;
               end else begin
                  role = ROLE_PADDING;
               end
            end
            KIND_PONG: begin
               if (r < TXID_L) begin
                  role = ROLE_TXID;
                  off  = r[4:0];
               end else if (r < PONG_ADDR_L) begin
                  role = ROLE_EP_ADDR;
                  off  = r_key[4:0];
               end else if (r < PONG_END_L) begin
                  role = ROLE_EP_PORT;
                  off  = r_port[4:0];
               end else begin
                  role = ROLE_IGNORED;
               end
            end
            KIND_CALL: begin
               if (group_count_ff < MAX_EP_L) begin
                  slot = group_count_ff[3:0];
                  if (group_phase_ff < ADDR_L) begin
                     role = ROLE_EP_ADDR;
                     off  = group_phase_ff;
                  end else begin
                     role = ROLE_EP_PORT;
                     off  = group_phase_ff - ADDR_L;
                  end
               end
               if (group_phase_ff == EP_LAST_L) begin
                  group_phase_in = 5'd0;
                  if (group_count_ff < MAX_EP_L) group_count_in = group_count_ff + 5'd1;
               end else begin
                  group_phase_in = group_phase_ff + 5'd1;
               end
            end
            default: role = ROLE_IGNORED;
         endcase
      end

      byte_count_in = (byte_count_ff <= MAX_L) ? byte_count_ff + CNT_W'(1) : byte_count_ff;
   end

   // end-of-message summary, from the state as it stands after this byte
   always_comb begin
      len       = byte_count_in;
      rest      = len - CNT_W'(2);
      after     = rest - TXID_L;
      after_key = after - KEY_L;
      kind_sum  = kind_of(type_seen_in, ping_code_ff, pong_code_ff, call_code_ff);
      status    = STAT_OK;
      has_key   = 1'b0;
      pad       = 12'd0;
      ep_cnt    = 5'd0;

      if (len > MAX_L) begin
         status = STAT_TOO_LONG;
      end else if (len < CNT_W'(2)) begin
         status = STAT_INVALID;
      end else begin
         case (kind_sum)
            KIND_PING: begin
               if (rest < TXID_L) begin
                  status = STAT_INVALID;
               end else begin
                  has_key = (after >= KEY_L) && key_nonzero_in;
                  pad     = has_key ? after_key : after;
               end
            end
            KIND_PONG: begin
               if (rest < PONG_END_L) status = STAT_INVALID;
            end
            KIND_CALL: begin
               if (version_seen_in == 8'd0 && rest != CNT_W'(0) && rest_phase_in == 5'd0)
                  ep_cnt = rest_groups_in;
            end
            default: status = STAT_UNSUPPORTED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         type_seen_ff    <= '0;
         version_seen_ff <= '0;
         key_nonzero_ff  <= 1'b0;
         group_phase_ff  <= '0;
         group_count_ff  <= '0;
         rest_phase_ff   <= '0;
         rest_groups_ff  <= '0;
      end else if (consume) begin
         if (stg_last_ff) begin
            byte_count_ff   <= '0;
            type_seen_ff    <= '0;
            version_seen_ff <= '0;
            key_nonzero_ff  <= 1'b0;
            group_phase_ff  <= '0;
            group_count_ff  <= '0;
            rest_phase_ff   <= '0;
            rest_groups_ff  <= '0;
         end else begin
            byte_count_ff   <= byte_count_in;
            type_seen_ff    <= type_seen_in;
            version_seen_ff <= version_seen_in;
            key_nonzero_ff  <= key_nonzero_in;
            group_phase_ff  <= group_phase_in;
            group_count_ff  <= group_count_in;
            rest_phase_ff   <= rest_phase_in;
            rest_groups_ff  <= rest_groups_in;
         end
      end
   end

   always_comb begin
      q_push.push = consume;
      q_push.pair = stg_last_ff;

      rec_byte                = '0;
      rec_byte.kind           = REC_BYTE;
      rec_byte.byte_value     = stg_byte_ff;
      rec_byte.byte_role      = role;
      rec_byte.field_offset   = off;
      rec_byte.endpoint_slot  = slot;
      rec_byte.status         = STAT_OK;

      rec_sum                 = '0;
      rec_sum.kind            = REC_SUMMARY;
      rec_sum.byte_role       = ROLE_TYPE;
      rec_sum.message_type    = type_seen_in;
      rec_sum.status          = status;
      rec_sum.key_present     = has_key;
      rec_sum.padding_len     = pad;
      rec_sum.endpoint_count  = ep_cnt;
   end

endmodule

// ===== design/dpp_out_fifo.sv =====
// Result queue: takes one or two records per cycle, hands out one per cycle while out_ready is high.
// Depends on dpp_pkg.
module dpp_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  dpp_pkg::push_type q_push,
   input  dpp_pkg::rec_type  rec_byte,
   input  dpp_pkg::rec_type  rec_sum,
   output logic              q_room,
   output logic              out_valid,
   input  logic              out_ready,
   output dpp_pkg::rec_type  out_rec
);
   import dpp_pkg::*;

   rec_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_nxt;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_CNT_W-1:0]   push_n;
   logic                    pop;

   // room for a full pair regardless of the output side
   assign q_room     = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign out_valid  = count_ff != '0;
   assign out_rec    = mem_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;
   assign push_n     = !q_push.push ? FIFO_CNT_W'(0)
                     : (q_push.pair ? FIFO_CNT_W'(2) : FIFO_CNT_W'(1));
   assign wr_ptr_nxt = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + push_n[FIFO_PTR_W-1:0];
   assign rd_ptr_in  = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in   = count_ff + push_n - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         mem_ff[wr_ptr_ff] <= rec_byte;
         if (q_push.pair) mem_ff[wr_ptr_nxt] <= rec_sum;
      end
   end

endmodule

// ===== design/disco_payload_parser.sv =====
// Discovery payload parser: one payload byte per item in, tagged byte records and
// an end-of-message summary out. Accepts one byte per clock while the output keeps
// up. An accepted byte sits in a stage register, is classified and is written into a
// four-entry result queue once the queue has room; rsp_tvalid comes from the queue's
// registered count. A last byte pushes two records (byte plus summary), and the
// queue drains one record per cycle while rsp_tready is high, so a message of N
// bytes yields N+1 records; input stalls while the queue holds more than two records.
// Type codes come from csr_addr 0/1/2 (ping, pong, call). There is no clearing pass
// after reset. Depends on dpp_pkg, dpp_parser and dpp_out_fifo.
module disco_payload_parser #(
   parameter int TXID_BYTES    = dpp_pkg::TXID_BYTES_DEF,
   parameter int MAX_ENDPOINTS = dpp_pkg::MAX_ENDPOINTS_DEF,
   parameter int MAX_PAYLOAD   = dpp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dpp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // data_byte[7:0]
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // byte_value[7:0], byte_role[10:8], field_offset[15:11], endpoint_slot[19:16],
   // message_type[27:20], status[29:28], key_present[30], padding_len[42:31],
   // endpoint_count[47:43]
   output logic [dpp_pkg::TDATA_W-1:0]       rsp_tdata,
   output logic                              rsp_tuser   // record_kind
);
   import dpp_pkg::*;

   `include "disco_payload_parser_defines.svh"

   push_type q_push;
   rec_type  rec_byte, rec_sum, out_rec;
   logic     q_room;

   dpp_parser #(
      .TXID_BYTES    (TXID_BYTES),
      .MAX_ENDPOINTS (MAX_ENDPOINTS),
      .MAX_PAYLOAD   (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .q_room    (q_room),
      .q_push    (q_push),
      .rec_byte  (rec_byte),
      .rec_sum   (rec_sum)
   );

   dpp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .rec_byte  (rec_byte),
      .rec_sum   (rec_sum),
      .q_room    (q_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tuser = out_rec.kind;
   assign rsp_tdata = {out_rec.endpoint_count, out_rec.padding_len, out_rec.key_present,
                       out_rec.status, out_rec.message_type, out_rec.endpoint_slot,
                       out_rec.field_offset, out_rec.byte_role, out_rec.byte_value};

   `DPP_ASSERT_IMP(a_sum_byte_fields_zero, clock, reset,
      rsp_tvalid && rsp_tuser, rsp_tdata[19:0] == 20'd0,
      "summary record carries byte fields")
   `DPP_ASSERT_IMP(a_byte_sum_fields_zero, clock, reset,
      rsp_tvalid && !rsp_tuser, rsp_tdata[47:20] == 28'd0,
      "byte record carries summary fields")
   `DPP_ASSERT_IMP(a_bad_status_clean, clock, reset,
      rsp_tvalid && rsp_tuser && rsp_tdata[29:28] != STAT_OK, rsp_tdata[47:30] == 18'd0,
      "failed summary reports key or padding or endpoints")
   `DPP_ASSERT_IMP(a_ep_count_capped, clock, reset,
      rsp_tvalid && rsp_tuser, rsp_tdata[47:43] <= 5'(MAX_ENDPOINTS),
      "endpoint count above cap")
   `DPP_ASSERT_NXT(a_pair_lands, clock, reset,
      q_push.push && q_push.pair && !rsp_tvalid, rsp_tvalid && !rsp_tuser,
      "byte record of a last byte not at queue head")

endmodule
